>>> rtl/core/scs_pkg.sv
// Shared types and constants for the sector cache score-replacement block.
package scs_pkg;

    // Field widths of the channels and the configuration port
    localparam int SECTOR_W  = 32;
    localparam int IDX_OUT_W = 5;
    localparam int CYL_W     = 16;
    localparam int HEAD_W    = 4;
    localparam int TSEC_W    = 8;
    localparam int GEO_W     = 8;
    localparam int PER_CYL_W = 2 * GEO_W;
    localparam int CFG_IDX_W = 1;

    // Score given to a freshly filled entry
    localparam int FILL_SCORE = 10;

    // Shared divider step counts
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEPS_CYL  = 6'd32;
    localparam logic [STEP_W-1:0] STEPS_HEAD = 6'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT   = 1'b1;

    // Request to the shared divider
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    // Status of the tag scan
    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_stat;

endpackage

>>> rtl/core/scs_item_if.sv
// Input channel carrying one sector request per transfer.
interface scs_item_if;
    logic                          valid;
    logic                          ready;
    logic [scs_pkg::SECTOR_W-1:0]  sector_number;
    logic                          last_in_request;

    modport source (output valid, output sector_number, output last_in_request, input ready);
    modport sink   (input valid, input sector_number, input last_in_request, output ready);
endinterface

>>> rtl/core/scs_result_if.sv
// Output channel carrying one lookup result per transfer.
interface scs_result_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [scs_pkg::IDX_OUT_W-1:0]  entry_index;
    logic [scs_pkg::CYL_W-1:0]      cylinder;
    logic [scs_pkg::HEAD_W-1:0]     head;
    logic [scs_pkg::TSEC_W-1:0]     track_sector;
    logic                           last_out;

    modport source (output valid, output hit, output entry_index, output cylinder,
                    output head, output track_sector, output last_out, input ready);
    modport sink   (input valid, input hit, input entry_index, input cylinder,
                    input head, input track_sector, input last_out, output ready);
endinterface

>>> rtl/core/scs_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
module scs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  scs_pkg::t_div_req                 i_req,
    input  logic [scs_pkg::SECTOR_W-1:0]      i_dividend,
    input  logic [scs_pkg::PER_CYL_W-1:0]     i_divisor,
    output logic                              o_done,
    output logic [scs_pkg::SECTOR_W-1:0]      o_quotient,
    output logic [scs_pkg::PER_CYL_W-1:0]     o_remainder
);

    localparam int DW = scs_pkg::PER_CYL_W;
    localparam int QW = scs_pkg::SECTOR_W;

    logic                        r_busy;
    logic                        r_done;
    logic [scs_pkg::STEP_W-1:0]  r_cnt;
    logic [QW-1:0]               r_quo;
    logic [DW-1:0]               r_rem;
    logic [DW-1:0]               r_div;

    logic [DW:0]                 shifted;
    logic [DW:0]                 diff;
    logic                        fits;

    assign shifted = {r_rem, r_quo[QW-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == scs_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            // trial subtract, keep the difference when it fits
            if (fits) begin
                r_rem <= diff[DW-1:0];
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DW-1:0];
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> rtl/core/scs_scan.sv
// Tag and score store with a one-entry-per-cycle lookup scan and victim choice.
module scs_scan #(
    parameter int ENTRIES    = 32,
    parameter int SCORE_BITS = 16,
    parameter int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [scs_pkg::SECTOR_W-1:0]  i_key,
    output scs_pkg::t_scan_stat           o_stat,
    output logic [IDX_W-1:0]              o_index
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [SCORE_BITS-1:0] SCORE_MAX  = {SCORE_BITS{1'b1}};
    localparam logic [SCORE_BITS-1:0] SCORE_FILL = SCORE_BITS'(scs_pkg::FILL_SCORE);

    typedef enum logic [2:0] {
        SC_IDLE = 3'b001,
        SC_RUN  = 3'b010,
        SC_FILL = 3'b100
    } t_scan_state;

    t_scan_state r_state;

    logic [scs_pkg::SECTOR_W-1:0] r_tag_mem   [ENTRIES];
    logic [SCORE_BITS-1:0]        r_score_mem [ENTRIES];
    logic [ENTRIES-1:0]           r_valid;

    logic [CNT_W-1:0]             r_rd_cnt;
    logic                         r_pipe_v;
    logic [IDX_W-1:0]             r_pipe_idx;
    logic [scs_pkg::SECTOR_W-1:0] r_tag_q;
    logic [SCORE_BITS-1:0]        r_score_q;
    logic                         r_valid_q;
    logic [scs_pkg::SECTOR_W-1:0] r_key;

    logic                         r_hit;
    logic [IDX_W-1:0]             r_hit_idx;
    logic                         r_inv_found;
    logic [IDX_W-1:0]             r_inv_idx;
    logic                         r_min_set;
    logic [SCORE_BITS-1:0]        r_min;
    logic [IDX_W-1:0]             r_min_idx;
    logic                         r_done;
    logic [IDX_W-1:0]             r_out_idx;

    logic [IDX_W-1:0]             rd_addr;
    logic                         rd_more;
    logic                         tag_eq;
    logic                         match;
    logic [SCORE_BITS-1:0]        n_score;
    logic [IDX_W-1:0]             victim;
    logic                         scan_end;
    logic                         score_we;
    logic [IDX_W-1:0]             score_waddr;
    logic [SCORE_BITS-1:0]        score_wdata;
    logic                         fill_we;

    assign rd_addr  = r_rd_cnt[IDX_W-1:0];
    assign rd_more  = (r_rd_cnt != CNT_W'(ENTRIES));
    assign tag_eq   = (r_tag_q == r_key);
    assign match    = r_pipe_v && r_valid_q && tag_eq;
    assign victim   = r_inv_found ? r_inv_idx : r_min_idx;
    assign scan_end = (r_state == SC_RUN) && !r_pipe_v && !rd_more;
    assign fill_we  = (r_state == SC_FILL) && !r_hit;

    // Score update: raise on a match, lower other valid entries
    always_comb begin
        n_score = r_score_q;
        if (r_valid_q) begin
            if (tag_eq) begin
                if (r_score_q != SCORE_MAX) begin
                    n_score = r_score_q + 1'b1;
                end
            end else if (r_score_q != '0) begin
                n_score = r_score_q - 1'b1;
            end
        end
    end

    always_comb begin
        score_we    = 1'b0;
        score_waddr = r_pipe_idx;
        score_wdata = n_score;
        if (fill_we) begin
            score_we    = 1'b1;
            score_waddr = victim;
            score_wdata = SCORE_FILL;
        end else if ((r_state == SC_RUN) && r_pipe_v) begin
            score_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            r_tag_mem[victim] <= r_key;
        end
        if (score_we) begin
            r_score_mem[score_waddr] <= score_wdata;
        end
        r_tag_q   <= r_tag_mem[rd_addr];
        r_score_q <= r_score_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SC_IDLE;
            r_valid     <= '0;
            r_pipe_v    <= 1'b0;
            r_done      <= 1'b0;
            r_hit       <= 1'b0;
            r_inv_found <= 1'b0;
            r_min_set   <= 1'b0;
            r_rd_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                SC_IDLE: begin
                    if (i_start) begin
                        r_state     <= SC_RUN;
                        r_rd_cnt    <= '0;
                        r_pipe_v    <= 1'b0;
                        r_hit       <= 1'b0;
                        r_inv_found <= 1'b0;
                        r_min_set   <= 1'b0;
                    end
                end
                SC_RUN: begin
                    if (rd_more) begin
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                        r_pipe_v <= 1'b1;
                    end else begin
                        r_pipe_v <= 1'b0;
                    end
                    if (match) begin
                        r_hit <= 1'b1;
                    end
                    if (r_pipe_v && !r_valid_q) begin
                        r_inv_found <= 1'b1;
                    end
                    if (r_pipe_v && r_valid_q) begin
                        r_min_set <= 1'b1;
                    end
                    if (scan_end) begin
                        r_state <= SC_FILL;
                    end
                end
                SC_FILL: begin
                    if (!r_hit) begin
                        r_valid[victim] <= 1'b1;
                    end
                    r_done  <= 1'b1;
                    r_state <= SC_IDLE;
                end
                default: begin
                    r_state <= SC_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == SC_IDLE) && i_start) begin
            r_key <= i_key;
        end
        r_pipe_idx <= rd_addr;
        r_valid_q  <= r_valid[rd_addr];
        if (match) begin
            r_hit_idx <= r_pipe_idx;
        end
        if (r_pipe_v && !r_valid_q && !r_inv_found) begin
            r_inv_idx <= r_pipe_idx;
        end
        // strict compare keeps the lowest index on ties
        if (r_pipe_v && r_valid_q && (!r_min_set || (n_score < r_min))) begin
            r_min     <= n_score;
            r_min_idx <= r_pipe_idx;
        end
        if (r_state == SC_FILL) begin
            r_out_idx <= r_hit ? r_hit_idx : victim;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.hit  = r_hit;
    assign o_index     = r_out_idx;

endmodule

>>> rtl/core/sector_cache_score_replacement.sv
// Top level of the sector cache score-replacement block.
//
// Use: each transfer on i_item carries one linear sector number and an
// end-of-request flag. The block looks the sector up in a fully associative
// tag store of ENTRIES entries, ages the scores, refills a victim on a miss
// and returns one transfer on o_result: hit, entry index and, on a miss,
// cylinder, head and one-based track sector from the geometry registers.
// Geometry is set through i_cfg_we / i_cfg_index / i_cfg_data; the user must
// write it only while idle (the block does not enforce this). Either value at
// zero forces the translated fields to zero. The tag scan walks one entry per
// cycle while the shared divider runs 32 steps for the cylinder and 16 for
// the head; the result is loaded once both are done. i_item.ready is high
// only while the sequencer is idle, one item in flight at a time.
// Reset invalidates every entry at once through the valid flops and clears
// the geometry registers; there is no clearing pass.
// A stalled receiver holds the result in the output register; the next item
// is still taken, and its result waits until the register frees.
module sector_cache_score_replacement #(
    parameter int ENTRIES    = 32,
    parameter int SCORE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    scs_item_if.sink                          i_item,
    scs_result_if.source                      o_result,
    input  logic                              i_cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scs_pkg::GEO_W-1:0]         i_cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PAD_W = IDX_W + scs_pkg::IDX_OUT_W;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_DIV_CYL  = 4'b0010,
        ST_DIV_HEAD = 4'b0100,
        ST_FINISH   = 4'b1000
    } t_top_state;

    t_top_state r_state;

    logic [scs_pkg::GEO_W-1:0]     r_heads;
    logic [scs_pkg::GEO_W-1:0]     r_spt;
    logic                          r_geo_ok;
    logic                          r_last;
    logic                          r_scan_done;
    logic [scs_pkg::CYL_W-1:0]     r_cyl;
    logic [scs_pkg::HEAD_W-1:0]    r_head;
    logic [scs_pkg::TSEC_W-1:0]    r_tsec;

    logic                          r_out_valid;
    logic                          r_out_hit;
    logic [scs_pkg::IDX_OUT_W-1:0] r_out_idx;
    logic [scs_pkg::CYL_W-1:0]     r_out_cyl;
    logic [scs_pkg::HEAD_W-1:0]    r_out_head;
    logic [scs_pkg::TSEC_W-1:0]    r_out_tsec;
    logic                          r_out_last;

    logic                          accept;
    logic                          load_out;
    logic                          xlate;
    logic [scs_pkg::PER_CYL_W-1:0] per_cyl;
    logic [PAD_W-1:0]              idx_ext;

    scs_pkg::t_div_req             div_req;
    logic [scs_pkg::SECTOR_W-1:0]  div_dividend;
    logic [scs_pkg::PER_CYL_W-1:0] div_divisor;
    logic                          div_done;
    logic [scs_pkg::SECTOR_W-1:0]  div_quo;
    logic [scs_pkg::PER_CYL_W-1:0] div_rem;

    scs_pkg::t_scan_stat           scan_stat;
    logic [IDX_W-1:0]              scan_idx;

    assign accept   = i_item.valid && (r_state == ST_IDLE);
    assign load_out = (r_state == ST_FINISH) && r_scan_done
                      && (!r_out_valid || o_result.ready);
    assign per_cyl  = scs_pkg::PER_CYL_W'(r_heads) * scs_pkg::PER_CYL_W'(r_spt);
    assign xlate    = r_geo_ok && !scan_stat.hit;
    assign idx_ext  = PAD_W'(scan_idx);

    // Divider sequencing: cylinder first, then head from the remainder
    always_comb begin
        div_req.start = accept || ((r_state == ST_DIV_CYL) && div_done);
        if (r_state == ST_IDLE) begin
            div_req.steps = scs_pkg::STEPS_CYL;
            div_dividend  = i_item.sector_number;
            div_divisor   = per_cyl;
        end else begin
            // left-align the remainder so that 16 steps cover it
            div_req.steps = scs_pkg::STEPS_HEAD;
            div_dividend  = {div_rem, {(scs_pkg::SECTOR_W - scs_pkg::PER_CYL_W){1'b0}}};
            div_divisor   = scs_pkg::PER_CYL_W'(r_spt);
        end
    end

    scs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (div_req),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    scs_scan #(
        .ENTRIES    (ENTRIES),
        .SCORE_BITS (SCORE_BITS),
        .IDX_W      (IDX_W)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (i_item.sector_number),
        .o_stat  (scan_stat),
        .o_index (scan_idx)
    );

    // Geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heads <= '0;
            r_spt   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scs_pkg::CFG_HEADS: r_heads <= i_cfg_data;
                scs_pkg::CFG_SPT:   r_spt   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_scan_done <= 1'b0;
            end else if (scan_stat.done) begin
                r_scan_done <= 1'b1;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_DIV_CYL;
                    end
                end
                ST_DIV_CYL: begin
                    if (div_done) begin
                        r_state <= ST_DIV_HEAD;
                    end
                end
                ST_DIV_HEAD: begin
                    if (div_done) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload: hold translation results and the output transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last   <= i_item.last_in_request;
            r_geo_ok <= (r_heads != '0) && (r_spt != '0);
        end
        if ((r_state == ST_DIV_CYL) && div_done) begin
            r_cyl <= div_quo[scs_pkg::CYL_W-1:0];
        end
        if ((r_state == ST_DIV_HEAD) && div_done) begin
            r_head <= div_quo[scs_pkg::HEAD_W-1:0];
            r_tsec <= div_rem[scs_pkg::TSEC_W-1:0] + 1'b1;
        end
        if (load_out) begin
            r_out_hit  <= scan_stat.hit;
            r_out_idx  <= idx_ext[scs_pkg::IDX_OUT_W-1:0];
            r_out_cyl  <= xlate ? r_cyl  : '0;
            r_out_head <= xlate ? r_head : '0;
            r_out_tsec <= xlate ? r_tsec : '0;
            r_out_last <= r_last;
        end
    end

    assign i_item.ready          = (r_state == ST_IDLE);
    assign o_result.valid        = r_out_valid;
    assign o_result.hit          = r_out_hit;
    assign o_result.entry_index  = r_out_idx;
    assign o_result.cylinder     = r_out_cyl;
    assign o_result.head         = r_out_head;
    assign o_result.track_sector = r_out_tsec;
    assign o_result.last_out     = r_out_last;

endmodule

>>> bench/scs_lookup_checker.sv
`timescale 1ns / 1ps
// Sector cache lookup checker: predicts each lookup from its own tag store and compares results.
module scs_lookup_checker
    import scs_pkg::*;
#(
    parameter int ENTRIES    = 32,
    parameter int SCORE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    scs_item_if                  i_item,
    scs_result_if                i_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GEO_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic                 hit;
        logic [IDX_OUT_W-1:0] entry;
        logic [CYL_W-1:0]     cyl;
        logic [HEAD_W-1:0]    head;
        logic [TSEC_W-1:0]    tsec;
        logic                 last;
    } t_lookup;

    // Predicted tag store and geometry
    logic [SECTOR_W-1:0]   tag_r   [ENTRIES];
    logic                  valid_r [ENTRIES];
    logic [SCORE_BITS-1:0] score_r [ENTRIES];
    logic [GEO_W-1:0]      heads_r;
    logic [GEO_W-1:0]      spt_r;

    t_lookup lookup_q[$];
    int      fail_total = 0;

    // Age the store, refill a victim on a miss and work out the CHS address.
    function automatic t_lookup lookup_sector(input logic [SECTOR_W-1:0] sec, input logic last);
        t_lookup     r;
        int          victim;
        logic [31:0] per_cyl;
        logic [31:0] rem;
        r      = '0;
        r.last = last;
        victim = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i]) begin
                if (tag_r[i] == sec) begin
                    if (score_r[i] != {SCORE_BITS{1'b1}})
                        score_r[i] = score_r[i] + 1'b1;
                    r.hit   = 1'b1;
                    r.entry = IDX_OUT_W'(i);
                end else if (score_r[i] != '0) begin
                    score_r[i] = score_r[i] - 1'b1;
                end
            end
        end
        if (!r.hit) begin
            for (int i = 0; i < ENTRIES && victim < 0; i++)
                if (!valid_r[i]) victim = i;
            if (victim < 0) begin
                victim = 0;
                for (int i = 1; i < ENTRIES; i++)
                    if (score_r[i] < score_r[victim]) victim = i;
            end
            tag_r[victim]   = sec;
            valid_r[victim] = 1'b1;
            score_r[victim] = SCORE_BITS'(FILL_SCORE);
            r.entry         = IDX_OUT_W'(victim);
            if (heads_r != '0 && spt_r != '0) begin
                per_cyl = 32'(heads_r) * 32'(spt_r);
                rem     = sec % per_cyl;
                r.cyl   = CYL_W'(sec / per_cyl);
                r.head  = HEAD_W'(rem / 32'(spt_r));
                r.tsec  = TSEC_W'(rem % 32'(spt_r) + 32'd1);
            end
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup got;
        t_lookup want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tag_r[i]   = '0;
                valid_r[i] = 1'b0;
                score_r[i] = '0;
            end
            heads_r = '0;
            spt_r   = '0;
            lookup_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEADS: heads_r = i_cfg_data;
                    CFG_SPT:   spt_r   = i_cfg_data;
                    default: ;
                endcase
            end
            // Compare before pushing, so a result can never match the item taken at the same edge
            if (i_result.valid && i_result.ready) begin
                got = '{hit: i_result.hit, entry: i_result.entry_index,
                        cyl: i_result.cylinder, head: i_result.head,
                        tsec: i_result.track_sector, last: i_result.last_out};
                if (lookup_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
                    fail_total++;
                end else begin
                    want = lookup_q.pop_front();
                    check_field("hit",          32'(want.hit),   32'(got.hit));
                    check_field("entry_index",  32'(want.entry), 32'(got.entry));
                    check_field("cylinder",     32'(want.cyl),   32'(got.cyl));
                    check_field("head",         32'(want.head),  32'(got.head));
                    check_field("track_sector", 32'(want.tsec),  32'(got.tsec));
                    check_field("last_out",     32'(want.last),  32'(got.last));
                end
            end
            if (i_item.valid && i_item.ready)
                lookup_q.push_back(lookup_sector(i_item.sector_number, i_item.last_in_request));
        end
        o_pending    <= lookup_q.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> bench/sector_cache_score_replacement_tb.sv
`timescale 1ns / 1ps
// Testbench top for the sector cache score-replacement block: stimulus, geometry phases, verdict.
module sector_cache_score_replacement_tb;
    import scs_pkg::*;

    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 240;
    localparam int HOLD_CYCLES  = 400;
    localparam int POOL_DEPTH   = 40;
    localparam int SETTLE_LEN   = 60;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [GEO_W-1:0]     i_cfg_data;
    int                   fail_count;
    int                   pending_count;

    // Idle rates in percent, set per phase and read by the driving processes
    int src_idle_pct = 22;
    int snk_idle_pct = 52;
    // Raised by the stimulus to make the receiver hold off for a long stretch
    bit hold_off_req = 1'b0;

    // Recently requested sectors, replayed to make hits and keep the store under pressure
    logic [SECTOR_W-1:0] recent_q[$];

    scs_item_if   item_ch();
    scs_result_if result_ch();

    sector_cache_score_replacement dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    scs_lookup_checker lookup_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Offer one sector request, with random idle cycles ahead of it, and hold until the
    // transfer happens. Valid stays high into the next request when no idle cycle is drawn.
    task automatic send_item(input logic [SECTOR_W-1:0] sec, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.sector_number   <= sec;
        item_ch.last_in_request <= last;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid and hold until every predicted result has been transferred out.
    // One edge passes first so that a transfer at the current edge is already counted.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // Write both geometry registers; only called once the block has drained.
    task automatic write_geometry(input logic [GEO_W-1:0] heads, input logic [GEO_W-1:0] spt);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HEADS;
        i_cfg_data  <= heads;
        @(posedge i_clk);
        i_cfg_index <= CFG_SPT;
        i_cfg_data  <= spt;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Receiver: random back-pressure, or a long hold-off on request so that the output
    // register stays full, the next item is taken, and the input channel then stalls.
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Stimulus: directed corner cases, then random phases, one geometry per phase
    initial begin
        logic [SECTOR_W-1:0] sec;
        int                  roll;

        i_rst_n                 <= 1'b0;
        i_cfg_we                <= 1'b0;
        i_cfg_index             <= CFG_HEADS;
        i_cfg_data              <= '0;
        item_ch.valid           <= 1'b0;
        item_ch.sector_number   <= '0;
        item_ch.last_in_request <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Geometry unset after reset: misses report zero CHS; sector zero and the
        // all-ones sector behave as ordinary tags, hits report zero CHS
        send_item('0, 1'b1);
        send_item('0, 1'b0);
        send_item('1, 1'b1);
        send_item('1, 1'b0);
        send_item(32'hFFFF_FFFE, 1'b1);

        // Track and cylinder boundaries, then cylinder truncation
        write_geometry(8'd16, 8'd63);
        send_item(32'd1007, 1'b0);
        send_item(32'd1008, 1'b1);
        send_item(32'd1007, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);

        // Largest geometry: cylinder and head both truncated
        write_geometry(8'd255, 8'd255);
        send_item(32'hFFFF_FFFD, 1'b0);
        send_item(32'd65024, 1'b1);
        send_item(32'd65025, 1'b0);

        // Either geometry value at zero disables translation
        write_geometry(8'd0, 8'd63);
        send_item(32'd5000, 1'b1);
        write_geometry(8'd16, 8'd0);
        send_item(32'd5001, 1'b0);

        // Single head with the widest track, then single sector per track
        write_geometry(8'd1, 8'd255);
        send_item(32'd254, 1'b1);
        send_item(32'd255, 1'b0);
        write_geometry(8'd255, 8'd1);
        send_item(32'd300, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: write_geometry(8'd1, 8'd1);
                1: write_geometry(8'd16, 8'd63);
                2: write_geometry(8'd255, 8'd255);
                3: write_geometry(8'd0, GEO_W'($urandom_range(1, 255)));
                default: write_geometry(GEO_W'($urandom_range(1, 255)),
                                        GEO_W'($urandom_range(1, 255)));
            endcase
            // Receiver idles more than the sender, then the reverse, then neither idles
            if (ph < 2) begin
                src_idle_pct = 22;
                snk_idle_pct = 52;
            end else if (ph < 4) begin
                src_idle_pct = 52;
                snk_idle_pct = 22;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 40 && (ph % 2) == 0) hold_off_req = 1'b1;
                if (n == 150) wait_drained();

                // Mostly replay recent sectors (hits and score ageing); the rest are fresh
                // small sectors for readable CHS, the extremes, or fully random tags
                roll = $urandom_range(99);
                if (roll < 55 && recent_q.size() > 0) begin
                    sec = recent_q[$urandom_range(recent_q.size() - 1)];
                end else begin
                    if (roll < 70)
                        sec = SECTOR_W'($urandom_range(70000));
                    else if (roll < 73)
                        sec = $urandom_range(1) ? '1 : '0;
                    else
                        sec = $urandom;
                    recent_q.push_back(sec);
                    if (recent_q.size() > POOL_DEPTH) void'(recent_q.pop_front());
                end
                send_item(sec, 1'($urandom_range(1)));
            end
        end

        wait_drained();
        repeat (SETTLE_LEN) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Guard against a hang anywhere in the run
    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
